// ===== hdl/spsa_pkg.sv =====
// Shared types and constants of the scratch page slot allocator.
// No dependencies; every other file of the block but spsa_ram imports this package.
package spsa_pkg;

    localparam int ADDR_W          = 64;
    localparam int FRAME_W         = 40;
    localparam int ENTRY_W         = 10;
    localparam int ACTION_W        = 2;
    localparam int STATUS_W        = 2;
    localparam int PAGE_SHIFT      = 12;
    localparam int PAGE_W          = ADDR_W - PAGE_SHIFT;
    localparam int SLOTS_PER_TABLE = 512;
    localparam int WORD_BITS       = 64;
    localparam int BIT_W           = 6;
    localparam int BYTES_PER_WORD  = WORD_BITS / 8;

    localparam logic [ACTION_W-1:0] ACT_ALLOC    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REASSIGN = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FREE     = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic scan;
        logic set_full;
        logic find;
        logic alloc_wr;
        logic look;
        logic act;
        logic load_out;
    } spsa_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic found;
        logic exhausted;
        logic out_free;
    } spsa_sts_t;

endpackage

// ===== hdl/spsa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module spsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/spsa_ctrl.sv =====
// Controller state machine of the scratch page slot allocator.
// Depends on spsa_pkg; drives the command struct of spsa_dp.
module spsa_ctrl
    import spsa_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic [ACTION_W-1:0] s_action,
    output logic                s_ready,
    input  spsa_sts_t           sts,
    output spsa_cmd_t           cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_FIND   = 7'b0000100,
        S_UPDATE = 7'b0001000,
        S_LOOK   = 7'b0010000,
        S_ACT    = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    unique case (s_action)
                        ACT_ALLOC:          state_next = S_SCAN;
                        ACT_REASSIGN,
                        ACT_FREE:           state_next = S_LOOK;
                        default:            state_next = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.found) begin
                    state_next = S_FIND;
                end else if (sts.exhausted) begin
                    cmd.set_full = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_FIND: begin
                cmd.find   = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE: begin
                cmd.alloc_wr = 1'b1;
                state_next   = S_DONE;
            end
            S_LOOK: begin
                cmd.look   = 1'b1;
                state_next = S_ACT;
            end
            S_ACT: begin
                cmd.act    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/spsa_dp.sv =====
// Datapath of the scratch page slot allocator: request registers, bitmap
// RAM with per-word valid bits, scan pipeline, result and output registers.
// Depends on spsa_pkg and spsa_ram; commanded by spsa_ctrl.
module spsa_dp
    import spsa_pkg::*;
#(
    parameter int TABLE_COUNT = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [ADDR_W-1:0]   cfg_wdata,
    input  logic [ACTION_W-1:0] s_action,
    input  logic [FRAME_W-1:0]  s_phys_frame,
    input  logic [ADDR_W-1:0]   s_virt_addr,
    input  logic                m_ready,
    input  spsa_cmd_t           cmd,
    output spsa_sts_t           sts,
    output logic                m_valid,
    output logic [ADDR_W-1:0]   m_slot_addr,
    output logic [STATUS_W-1:0] m_status,
    output logic [ENTRY_W-1:0]  m_entry_index,
    output logic [FRAME_W-1:0]  m_entry_frame,
    output logic                m_invalidate
);

    localparam int SLOT_TOTAL = TABLE_COUNT * SLOTS_PER_TABLE;
    localparam int WORDS      = SLOT_TOTAL / WORD_BITS;
    localparam int AW         = $clog2(WORDS);
    localparam int IW         = AW + BIT_W;
    localparam int CW         = AW + 1;

    function automatic logic [2:0] first_set8(input logic [7:0] v);
        logic [2:0] pos;
        pos = '0;
        for (int i = 7; i >= 0; i--) begin
            if (v[i]) begin
                pos = 3'(i);
            end
        end
        return pos;
    endfunction

    // Control state.
    logic [ADDR_W-1:0]   base_reg;
    logic [WORDS-1:0]    bm_vld_reg;
    logic                chk_pend_reg;
    logic [CW-1:0]       scan_cnt_reg;
    logic                m_valid_reg;

    // Payload.
    logic [ACTION_W-1:0] op_reg;
    logic [FRAME_W-1:0]  frame_reg;
    logic [PAGE_W-1:0]   diff_reg;
    logic [AW-1:0]       chk_addr_reg;
    logic [WORD_BITS-1:0] found_word_reg;
    logic [AW-1:0]       found_addr_reg;
    logic [BYTES_PER_WORD-1:0] byte_zero_reg;
    logic [IW-1:0]       slot_idx_reg;
    logic [WORD_BITS-1:0] new_word_reg;
    logic                in_range_reg;
    logic                hit_vld_reg;
    logic [ADDR_W-1:0]   res_addr_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [ENTRY_W-1:0]  res_index_reg;
    logic [FRAME_W-1:0]  res_frame_reg;
    logic                res_inval_reg;
    logic [ADDR_W-1:0]   m_addr_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [ENTRY_W-1:0]  m_index_reg;
    logic [FRAME_W-1:0]  m_frame_reg;
    logic                m_inval_reg;

    // RAM port signals.
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    // Combinational helpers.
    logic [ADDR_W-1:0]    diff_full;
    logic [WORD_BITS-1:0] chk_word;
    logic                 scan_hit;
    logic [BYTES_PER_WORD-1:0] chk_byte_zero;
    logic [2:0]           byte_sel;
    logic [7:0]           sel_byte;
    logic [2:0]           bit_sel;
    logic [BIT_W-1:0]     bit_pos;
    logic [AW-1:0]        look_waddr;
    logic                 look_in_range;
    logic [WORD_BITS-1:0] act_word;
    logic [BIT_W-1:0]     act_bit_pos;
    logic                 free_ok;

    spsa_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(WORDS)
    ) u_bitmap (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign diff_full = s_virt_addr - base_reg;

    // A word that was never written since reset reads as all slots free.
    assign chk_word = bm_vld_reg[chk_addr_reg] ? ram_rdata : '0;
    assign scan_hit = chk_pend_reg && (~chk_word != '0);

    always_comb begin
        for (int b = 0; b < BYTES_PER_WORD; b++) begin
            chk_byte_zero[b] = ~&chk_word[b*8 +: 8];
        end
    end

    assign byte_sel = first_set8(byte_zero_reg);
    assign sel_byte = found_word_reg[byte_sel*8 +: 8];
    assign bit_sel  = first_set8(~sel_byte);
    assign bit_pos  = {byte_sel, bit_sel};

    assign look_waddr    = diff_reg[IW-1:BIT_W];
    assign look_in_range = diff_reg < PAGE_W'(SLOT_TOTAL);

    assign act_word    = hit_vld_reg ? ram_rdata : '0;
    assign act_bit_pos = diff_reg[BIT_W-1:0];
    assign free_ok     = in_range_reg && act_word[act_bit_pos];

    assign ram_raddr = cmd.scan ? scan_cnt_reg[AW-1:0] : look_waddr;
    assign ram_we    = cmd.alloc_wr || (cmd.act && (op_reg == ACT_FREE) && free_ok);
    assign ram_waddr = cmd.alloc_wr ? found_addr_reg : look_waddr;
    assign ram_wdata = cmd.alloc_wr ? new_word_reg
                                    : (act_word & ~(WORD_BITS'(1) << act_bit_pos));

    assign sts.found     = scan_hit;
    assign sts.exhausted = chk_pend_reg && !scan_hit && (chk_addr_reg == AW'(WORDS - 1));
    assign sts.out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg     <= '0;
            bm_vld_reg   <= '0;
            chk_pend_reg <= 1'b0;
            scan_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                base_reg <= cfg_wdata;
            end
            if (ram_we) begin
                bm_vld_reg[ram_waddr] <= 1'b1;
            end
            if (cmd.accept) begin
                scan_cnt_reg <= '0;
                chk_pend_reg <= 1'b0;
            end else if (cmd.scan) begin
                if (scan_cnt_reg < CW'(WORDS)) begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    chk_pend_reg <= 1'b1;
                end else begin
                    chk_pend_reg <= 1'b0;
                end
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg         <= s_action;
            frame_reg      <= s_phys_frame;
            diff_reg       <= diff_full[ADDR_W-1:PAGE_SHIFT];
            res_addr_reg   <= '0;
            res_status_reg <= ST_OK;
            res_index_reg  <= '0;
            res_frame_reg  <= '0;
            res_inval_reg  <= 1'b0;
        end
        if (cmd.scan) begin
            chk_addr_reg <= scan_cnt_reg[AW-1:0];
            if (scan_hit) begin
                found_word_reg <= chk_word;
                found_addr_reg <= chk_addr_reg;
                byte_zero_reg  <= chk_byte_zero;
            end
        end
        if (cmd.set_full) begin
            res_status_reg <= ST_FULL;
        end
        if (cmd.find) begin
            slot_idx_reg <= {found_addr_reg, bit_pos};
            new_word_reg <= found_word_reg | (WORD_BITS'(1) << bit_pos);
        end
        if (cmd.alloc_wr) begin
            res_addr_reg  <= base_reg + (ADDR_W'(slot_idx_reg) << PAGE_SHIFT);
            res_index_reg <= ENTRY_W'(slot_idx_reg);
            res_frame_reg <= frame_reg;
            res_inval_reg <= 1'b1;
        end
        if (cmd.look) begin
            in_range_reg <= look_in_range;
            hit_vld_reg  <= look_in_range && bm_vld_reg[look_waddr];
        end
        if (cmd.act) begin
            if (op_reg == ACT_REASSIGN) begin
                if (in_range_reg) begin
                    res_index_reg <= ENTRY_W'(diff_reg[IW-1:0]);
                    res_frame_reg <= frame_reg;
                    res_inval_reg <= 1'b1;
                end else begin
                    res_status_reg <= ST_BAD;
                end
            end else if (!free_ok) begin
                res_status_reg <= ST_BAD;
            end
        end
        if (cmd.load_out) begin
            m_addr_reg   <= res_addr_reg;
            m_status_reg <= res_status_reg;
            m_index_reg  <= res_index_reg;
            m_frame_reg  <= res_frame_reg;
            m_inval_reg  <= res_inval_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_slot_addr   = m_addr_reg;
    assign m_status      = m_status_reg;
    assign m_entry_index = m_index_reg;
    assign m_entry_frame = m_frame_reg;
    assign m_invalidate  = m_inval_reg;

endmodule

// ===== hdl/scratch_page_slot_allocator.sv =====
// Scratch page slot allocator, top level: spsa_ctrl drives spsa_dp (uses spsa_pkg).
// From request acceptance to m_valid: allocate passes S_SCAN, S_FIND, S_UPDATE and
// S_DONE (S_SCAN goes straight to S_DONE when the window is full), reassign and free
// pass S_LOOK, S_ACT and S_DONE, an unknown action S_DONE. The word scan sets the allocate time.
// One request in flight: a new request is taken only after the result is loaded out.
// Reset (aresetn low, synchronous) frees every slot and zeroes the window base, base_reg.
module scratch_page_slot_allocator
    import spsa_pkg::*;
#(
    parameter int TABLE_COUNT = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [ADDR_W-1:0]   cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [ACTION_W-1:0] s_action,
    input  logic [FRAME_W-1:0]  s_phys_frame,
    input  logic [ADDR_W-1:0]   s_virt_addr,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [ADDR_W-1:0]   m_slot_addr,
    output logic [STATUS_W-1:0] m_status,
    output logic [ENTRY_W-1:0]  m_entry_index,
    output logic [FRAME_W-1:0]  m_entry_frame,
    output logic                m_invalidate
);

    // The used bits live in a RAM of 64-bit words, one bit per slot. Each word
    // has a valid flop cleared by reset; a word never written reads as free.
    // An allocate streams the words through the RAM read port, one per cycle,
    // stops at the first word with a zero bit, locates that bit in two steps
    // (byte, then bit) and writes the word back with the bit set. Reassign and
    // free translate the address with one subtract, range check it, then read
    // the one word they need. s_ready is high only in the idle state.

    spsa_cmd_t cmd;
    spsa_sts_t sts;

    spsa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_action(s_action),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // The frame number is not stored in the bitmap: it leaves on m_entry_frame with
    // the page entry write that it belongs to.
    spsa_dp #(
        .TABLE_COUNT(TABLE_COUNT)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_action     (s_action),
        .s_phys_frame (s_phys_frame),
        .s_virt_addr  (s_virt_addr),
        .m_ready      (m_ready),
        .cmd          (cmd),
        .sts          (sts),
        .m_valid      (m_valid),
        .m_slot_addr  (m_slot_addr),
        .m_status     (m_status),
        .m_entry_index(m_entry_index),
        .m_entry_frame(m_entry_frame),
        .m_invalidate (m_invalidate)
    );

endmodule

// ===== hdl/spsa_chk.sv =====
// Port-level checker of the scratch page slot allocator, bound to the top level.
// Depends on spsa_pkg.
module spsa_chk
    import spsa_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [ADDR_W-1:0]   m_slot_addr,
    input logic [STATUS_W-1:0] m_status,
    input logic                m_invalidate
);

    // Only one request is worked on at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while another is in flight");

    // A full window reports no address and no entry write.
    a_full_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_FULL)) |-> (m_slot_addr == '0) && !m_invalidate)
        else $error("full status with address or invalidate");

    // An entry write only comes with an ok status.
    a_inval_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_invalidate) |-> (m_status == ST_OK))
        else $error("invalidate with a failing status");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_slot_addr) && $stable(m_status))
        else $error("stalled result changed");

endmodule

bind scratch_page_slot_allocator spsa_chk u_spsa_chk (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_slot_addr (m_slot_addr),
    .m_status    (m_status),
    .m_invalidate(m_invalidate)
);
